### src/ole_pkg.sv
// Shared types and constants for the ordered list engine.
package ole_pkg;

  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int ST_W   = 2;
  localparam int OUT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD   = 3'd0,
    CMD_INS_TAIL   = 3'd1,
    CMD_INS_BEFORE = 3'd2,
    CMD_INS_AFTER  = 3'd3,
    CMD_DEL_HEAD   = 3'd4,
    CMD_DEL_TAIL   = 3'd5,
    CMD_DEL_KEY    = 3'd6,
    CMD_SEARCH     = 3'd7
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [3:0] {
    OP_HOLD,
    OP_START,      // token to the head cell, clear passed marks
    OP_SCAN,       // token moves one cell down the chain
    OP_SHR_ALL,    // whole chain shifts right, head cell loads data
    OP_SHL_ALL,    // whole chain shifts left
    OP_SHR_AT,     // token cell loads data, cells after it shift right
    OP_SHR_AFTER,  // cell after the token loads data, cells beyond shift right
    OP_SHL_AT,     // token cell and cells after it shift left
    OP_PUT_TAIL,   // first empty cell loads data
    OP_DROP_TAIL   // last occupied cell empties
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [DATA_W-1:0] data;
    logic signed [DATA_W-1:0] key;
  } cell_ctl_t;

  typedef struct packed {
    logic                     valid;
    logic                     tok;
    logic signed [DATA_W-1:0] value;
  } cell_link_t;

endpackage

### src/ole_cmd_if.sv
// Command channel: one list command per transfer.
interface ole_cmd_if import ole_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [DATA_W-1:0] value;
  logic signed [DATA_W-1:0] key;

  modport source (output valid, command, value, key, input ready);
  modport sink   (input valid, command, value, key, output ready);
endinterface

### src/ole_res_if.sv
// Result channel: status, match position and entry count per transfer.
interface ole_res_if import ole_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [OUT_W-1:0]  position;
  logic [OUT_W-1:0]  count;

  modport source (output valid, status, position, count, input ready);
  modport sink   (input valid, status, position, count, output ready);
endinterface

### src/ole_cell.sv
// One cell of the list chain: a value, its occupancy and the scan token.
module ole_cell import ole_pkg::*; #(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctl_t  ctl,
  input  cell_link_t left,
  input  cell_link_t right,
  output cell_link_t link,
  output logic       hit
);

  logic                     valid;
  logic                     tok;
  logic                     passed;
  logic signed [DATA_W-1:0] value;

  assign link = '{valid: valid, tok: tok, value: value};
  assign hit  = tok && valid && (value == ctl.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      tok    <= 1'b0;
      passed <= 1'b0;
    end else begin
      unique case (ctl.op)
        OP_HOLD: ;
        OP_START: begin
          tok    <= IS_HEAD;
          passed <= 1'b0;
        end
        OP_SCAN: begin
          tok    <= left.tok;
          passed <= passed | tok;
        end
        OP_SHR_ALL:   valid <= IS_HEAD ? 1'b1 : left.valid;
        OP_SHL_ALL:   valid <= right.valid;
        OP_SHR_AT: begin
          if (tok)          valid <= 1'b1;
          else if (!passed) valid <= left.valid;
        end
        OP_SHR_AFTER: begin
          if (left.tok)              valid <= 1'b1;
          else if (!passed && !tok)  valid <= left.valid;
        end
        OP_SHL_AT: begin
          if (!passed) valid <= right.valid;
        end
        OP_PUT_TAIL: begin
          if (!valid && left.valid) valid <= 1'b1;
        end
        OP_DROP_TAIL: begin
          if (valid && !right.valid) valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_SHR_ALL:   value <= IS_HEAD ? ctl.data : left.value;
      OP_SHL_ALL:   value <= right.value;
      OP_SHR_AT: begin
        if (tok)          value <= ctl.data;
        else if (!passed) value <= left.value;
      end
      OP_SHR_AFTER: begin
        if (left.tok)             value <= ctl.data;
        else if (!passed && !tok) value <= left.value;
      end
      OP_SHL_AT: begin
        if (!passed) value <= right.value;
      end
      OP_PUT_TAIL: begin
        if (!valid && left.valid) value <= ctl.data;
      end
      default: ;
    endcase
  end

endmodule

### src/ole_ctrl.sv
// Command sequencer: decodes a command, drives the cell chain, forms the result.
module ole_ctrl import ole_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst,
  ole_cmd_if.sink   cmd,
  ole_res_if.source res,
  input  logic      hit_any,
  output cell_ctl_t ctl
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_DONE} state_t;

  state_t                   state;
  cmd_t                     cmd_q;
  logic signed [DATA_W-1:0] val_q;
  logic signed [DATA_W-1:0] key_q;
  logic [CW-1:0]            cnt;
  logic [CW-1:0]            pos;
  status_t                  st_q;
  logic [CW-1:0]            pos_q;

  cell_op_t      op;
  logic          finish;
  status_t       fin_status;
  logic [CW-1:0] fin_pos;
  logic [CW-1:0] cnt_next;
  logic          full;
  logic          empty;

  assign full      = (cnt == CW'(CAPACITY));
  assign empty     = (cnt == '0);
  assign cmd.ready = (state == S_IDLE);
  assign ctl       = '{op: op, data: val_q, key: key_q};

  always_comb begin
    op         = OP_HOLD;
    finish     = 1'b0;
    fin_status = ST_OK;
    fin_pos    = '0;
    cnt_next   = cnt;
    unique case (state)
      S_EXEC: begin
        case (cmd_q) inside
          CMD_INS_HEAD, CMD_INS_TAIL: begin
            finish = 1'b1;
            if (full) begin
              fin_status = ST_FULL;
            end else begin
              op       = (cmd_q == CMD_INS_HEAD) ? OP_SHR_ALL : OP_PUT_TAIL;
              cnt_next = cnt + CW'(1);
            end
          end
          CMD_INS_BEFORE, CMD_INS_AFTER: begin
            if (full) begin
              finish     = 1'b1;
              fin_status = ST_FULL;
            end else begin
              op = OP_START;
            end
          end
          CMD_DEL_HEAD, CMD_DEL_TAIL: begin
            finish = 1'b1;
            if (empty) begin
              fin_status = ST_EMPTY;
            end else begin
              op       = (cmd_q == CMD_DEL_HEAD) ? OP_SHL_ALL : OP_DROP_TAIL;
              cnt_next = cnt - CW'(1);
            end
          end
          CMD_DEL_KEY: begin
            if (empty) begin
              finish     = 1'b1;
              fin_status = ST_EMPTY;
            end else begin
              op = OP_START;
            end
          end
          default: op = OP_START;
        endcase
      end
      S_SCAN: begin
        if (hit_any) begin
          finish = 1'b1;
          case (cmd_q)
            CMD_INS_BEFORE: begin
              op       = OP_SHR_AT;
              cnt_next = cnt + CW'(1);
            end
            CMD_INS_AFTER: begin
              op       = OP_SHR_AFTER;
              cnt_next = cnt + CW'(1);
            end
            CMD_DEL_KEY: begin
              op       = OP_SHL_AT;
              cnt_next = cnt - CW'(1);
            end
            default: fin_pos = pos + CW'(1);
          endcase
        end else if (pos == cnt) begin
          finish     = 1'b1;
          fin_status = ST_NOTFOUND;
        end else begin
          op = OP_SCAN;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      pos       <= '0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && state != S_DONE) res.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            cmd_q <= cmd_t'(cmd.command);
            val_q <= cmd.value;
            key_q <= cmd.key;
            state <= S_EXEC;
          end
        end
        S_EXEC, S_SCAN: begin
          cnt <= cnt_next;
          if (op == OP_START)     pos <= '0;
          else if (op == OP_SCAN) pos <= pos + CW'(1);
          if (op == OP_START) state <= S_SCAN;
          if (finish) begin
            st_q  <= fin_status;
            pos_q <= fin_pos;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res.valid || res.ready) begin
            res.valid    <= 1'b1;
            res.status   <= st_q;
            res.position <= OUT_W'(pos_q);
            res.count    <= OUT_W'(cnt);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> pos <= cnt)
    else $error("scan ran past the last entry");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC || state == S_SCAN) |=>
      (cnt == $past(cnt) || cnt == $past(cnt) + CW'(1) || cnt == $past(cnt) - CW'(1)))
    else $error("entry count moved by more than one");

  a_cnt_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |=> cnt == $past(cnt))
    else $error("entry count changed outside a command");
`endif

endmodule

### src/ordered_list_engine.sv
// Top level of the ordered list engine: sequencer plus chain of list cells.
//
//   channel  modport  payload                       role
//   cmd      sink     command[2:0] value[31:0] key  one list command per transfer
//   res      source   status[1:0] position count    one result per command
//
// Head and tail commands, and any command refused as full or empty, finish in
// the execute state. Key commands then go to the scan state and end when the
// key is found or every entry has been walked, as the scan token moves one
// cell per cycle.
// A new command is taken once the previous result is handed to the output
// register; a stalled result does not block the next command's work.
// Reset is synchronous and empties the list.
module ordered_list_engine import ole_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst,
  ole_cmd_if.sink   cmd,
  ole_res_if.source res
);

  // The head cell sees an occupied, token-free neighbour on its left so that
  // a tail insert into an empty list lands in it; the last cell sees empty.
  localparam cell_link_t HEAD_EDGE = '{valid: 1'b1, tok: 1'b0, value: '0};
  localparam cell_link_t TAIL_EDGE = '{valid: 1'b0, tok: 1'b0, value: '0};

  cell_ctl_t             ctl;
  cell_link_t            links [CAPACITY];
  logic [CAPACITY-1:0]   hit;
  logic [CAPACITY-1:0]   valid_vec;
  logic [CAPACITY-1:0]   tok_vec;
  logic                  hit_any;

  // At most one cell holds the token, so any hit is the first match.
  assign hit_any = |hit;

  ole_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .res     (res),
    .hit_any (hit_any),
    .ctl     (ctl)
  );

  // Chain the cells: each sees its neighbours' value, occupancy and token.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t left_in;
    cell_link_t right_in;

    if (i == 0) begin : g_first
      assign left_in = HEAD_EDGE;
    end else begin : g_mid_l
      assign left_in = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_in = TAIL_EDGE;
    end else begin : g_mid_r
      assign right_in = links[i+1];
    end

    ole_cell #(
      .IS_HEAD (i == 0)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .left  (left_in),
      .right (right_in),
      .link  (links[i]),
      .hit   (hit[i])
    );

    assign valid_vec[i] = links[i].valid;
    assign tok_vec[i]   = links[i].tok;
  end

`ifndef NO_ASSERTIONS
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_vec))
    else $error("more than one scan token in the chain");

  a_packed: assert property (@(posedge clk) disable iff (rst)
    (valid_vec[CAPACITY-1:1] & ~valid_vec[CAPACITY-2:0]) == '0)
    else $error("occupied cells are not packed towards the head");

  a_hit_tok: assert property (@(posedge clk) disable iff (rst)
    hit_any |-> $onehot(hit & tok_vec & valid_vec))
    else $error("match reported without a token on an occupied cell");
`endif

endmodule
